// ----- hdl/rau_pkg.sv -----
package rau_pkg;

    // operand width of every numerator and denominator
    localparam int W = 32;

    // stream payload widths (fields packed from bit 0, whole bytes)
    localparam int IN_DATA_W  = 4 * W;
    localparam int OUT_DATA_W = 2 * W;
    localparam int OP_W       = 3;

    // serial divider step counter
    localparam int CNT_W = $clog2(W);

    // request queue between front and back, power-of-two depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // opcodes as seen on the input stream
    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_SIMP = 3'd4;

    // request class decided by the front end
    typedef enum logic [2:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_SIMP,
        KIND_NONE
    } kind_t;

    // one queued request
    typedef struct packed {
        kind_t              kind;
        logic signed [W-1:0] a_num;
        logic signed [W-1:0] a_den;
        logic signed [W-1:0] b_num;
        logic signed [W-1:0] b_den;
    } job_t;

    // divider control from the back end
    typedef struct packed {
        logic         start;
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
    } div_req_t;

    // divider status and results
    typedef struct packed {
        logic         done;
        logic [W-1:0] quot;
        logic [W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/rau_front.sv -----
module rau_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rau_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [rau_pkg::OP_W-1:0]      s_tuser,
    output logic                          push_valid,
    output rau_pkg::job_t                 push_job,
    input  logic                          push_ready
);
    import rau_pkg::*;

    logic  valid_reg;
    job_t  job_reg;
    kind_t kind;

    // decode the opcode into a request class
    always_comb begin
        case (s_tuser)
            OP_ADD:  kind = KIND_ADD;
            OP_SUB:  kind = KIND_SUB;
            OP_MUL:  kind = KIND_MUL;
            OP_DIV:  kind = KIND_DIV;
            OP_SIMP: kind = KIND_SIMP;
            default: kind = KIND_NONE;
        endcase
    end

    // input stage is free when empty or draining into the queue
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_job   = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // capture the classified request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            job_reg.kind  <= kind;
            job_reg.a_num <= s_tdata[W-1:0];
            job_reg.a_den <= s_tdata[2*W-1:W];
            job_reg.b_num <= s_tdata[3*W-1:2*W];
            job_reg.b_den <= s_tdata[4*W-1:3*W];
        end
    end

endmodule

// ----- hdl/rau_fifo.sv -----
module rau_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  rau_pkg::job_t push_job,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output rau_pkg::job_t pop_job
);
    import rau_pkg::*;

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/rau_div.sv -----
module rau_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    logic             busy_reg;
    logic             fix_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsr_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;
    logic [W-1:0]     quot_reg;
    logic [W-1:0]     remo_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;
    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;

    // magnitudes; the most negative value maps to its unsigned weight
    assign mag_a = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
    assign mag_b = req.divisor[W-1]  ? (W'(0) - req.divisor)  : req.divisor;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = !diff[W];

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = remo_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    fix_reg  <= 1'b0;
                    cnt_reg  <= '0;
                end
            end else if (!fix_reg) begin
                if (cnt_reg == CNT_W'(W - 1)) begin
                    fix_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: load, shift-subtract, then sign fix-up
    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            if (req.start) begin
                quo_reg   <= mag_a;
                rem_reg   <= '0;
                dsr_reg   <= mag_b;
                neg_q_reg <= req.dividend[W-1] ^ req.divisor[W-1];
                neg_r_reg <= req.dividend[W-1];
            end
        end else if (!fix_reg) begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end else begin
            quot_reg <= neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
            remo_reg <= neg_r_reg ? (W'(0) - rem_reg) : rem_reg;
        end
    end

endmodule

// ----- hdl/rau_back.sv -----
module rau_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    output logic                           pop,
    input  logic                           pop_valid,
    input  rau_pkg::job_t                  pop_job,
    output rau_pkg::div_req_t              div_req,
    input  rau_pkg::div_rsp_t              div_rsp,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // res_num, res_den
    output logic [rau_pkg::OUT_DATA_W-1:0] m_tdata,
    // fault
    output logic                           m_tuser
);
    import rau_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL0     = 4'd1;
    localparam logic [3:0] ST_MUL1     = 4'd2;
    localparam logic [3:0] ST_MUL2     = 4'd3;
    localparam logic [3:0] ST_SUM      = 4'd4;
    localparam logic [3:0] ST_GCD_CHK  = 4'd5;
    localparam logic [3:0] ST_GCD_WAIT = 4'd6;
    localparam logic [3:0] ST_QN_WAIT  = 4'd7;
    localparam logic [3:0] ST_QD_WAIT  = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]   state_reg;
    job_t         job_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;
    logic [W-1:0] p0_reg;
    logic [W-1:0] p1_reg;
    logic [W-1:0] p2_reg;
    logic [W-1:0] rn_reg;
    logic [W-1:0] rd_reg;
    logic         f_reg;
    logic         out_valid_reg;
    logic [W-1:0] out_num_reg;
    logic [W-1:0] out_den_reg;
    logic         out_fault_reg;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] prod;

    assign pop      = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_den_reg, out_num_reg};
    assign m_tuser  = out_fault_reg;

    // shared multiplier, low word of the product only
    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_a = job_reg.a_num;
                mul_b = (job_reg.kind == KIND_MUL) ? job_reg.b_num : job_reg.b_den;
            end
            ST_MUL1: begin
                mul_a = job_reg.a_den;
                mul_b = (job_reg.kind == KIND_MUL) ? job_reg.b_den : job_reg.b_num;
            end
            default: begin
                mul_a = job_reg.a_den;
                mul_b = job_reg.b_den;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // divider requests: euclid remainder steps, then the two reductions
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = y_reg;
        case (state_reg)
            ST_GCD_CHK: begin
                if (y_reg != '0) begin
                    div_req.start = 1'b1;
                end else if (x_reg != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = job_reg.a_num;
                    div_req.divisor  = x_reg;
                end
            end
            ST_QN_WAIT: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = job_reg.a_den;
                div_req.divisor  = x_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        case (pop_job.kind)
                            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: state_reg <= ST_MUL0;
                            KIND_SIMP: state_reg <= ST_GCD_CHK;
                            default:   state_reg <= ST_SUM;
                        endcase
                    end
                end
                ST_MUL0:  state_reg <= ST_MUL1;
                ST_MUL1:  state_reg <= ST_MUL2;
                ST_MUL2:  state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_DONE;
                ST_GCD_CHK: begin
                    if (y_reg != '0) begin
                        state_reg <= ST_GCD_WAIT;
                    end else if (x_reg != '0) begin
                        state_reg <= ST_QN_WAIT;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_GCD_CHK;
                    end
                end
                ST_QN_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_QD_WAIT;
                    end
                end
                ST_QD_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    job_reg <= pop_job;
                    x_reg   <= pop_job.a_num;
                    y_reg   <= pop_job.a_den;
                end
            end
            ST_MUL0: p0_reg <= prod;
            ST_MUL1: p1_reg <= prod;
            ST_MUL2: p2_reg <= prod;
            ST_SUM: begin
                f_reg <= 1'b0;
                case (job_reg.kind)
                    KIND_ADD: begin
                        rn_reg <= p0_reg + p1_reg;
                        rd_reg <= p2_reg;
                    end
                    KIND_SUB: begin
                        rn_reg <= p0_reg - p1_reg;
                        rd_reg <= p2_reg;
                    end
                    KIND_MUL, KIND_DIV: begin
                        rn_reg <= p0_reg;
                        rd_reg <= p1_reg;
                    end
                    default: begin
                        rn_reg <= '0;
                        rd_reg <= '0;
                    end
                endcase
            end
            ST_GCD_CHK: begin
                // zero gcd only when A is 0/0
                if (y_reg == '0 && x_reg == '0) begin
                    rn_reg <= job_reg.a_num;
                    rd_reg <= job_reg.a_den;
                    f_reg  <= 1'b1;
                end
            end
            ST_GCD_WAIT: begin
                if (div_rsp.done) begin
                    x_reg <= y_reg;
                    y_reg <= div_rsp.rem;
                end
            end
            ST_QN_WAIT: begin
                if (div_rsp.done) begin
                    rn_reg <= div_rsp.quot;
                end
            end
            ST_QD_WAIT: begin
                if (div_rsp.done) begin
                    rd_reg <= div_rsp.quot;
                    f_reg  <= 1'b0;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_num_reg   <= rn_reg;
                    out_den_reg   <= rd_reg;
                    out_fault_reg <= f_reg;
                end
            end
            default: begin
                f_reg <= f_reg;
            end
        endcase
    end

endmodule

// ----- hdl/rational_arithmetic_unit_core.sv -----
// Rational arithmetic on two fractions A = a_num/a_den and B = b_num/b_den, all
// 32-bit two's complement. Opcode 0..3 (add, subtract, multiply, divide) works by
// cross-multiplication without reduction, every product and sum wrapping to 32 bits;
// these take three passes through one shared 32x32 multiplier plus the final add.
// Opcode 4 reduces A by Euclid's gcd with truncating remainder (so the gcd, and
// hence the signs, follow C); each remainder and each of the two final quotients
// goes through the bit-serial divider. A 0/0 input to opcode 4 returns A unchanged
// with fault set in m_tuser; opcodes 5..7 return 0/0 with no fault. The front end
// accepts and decodes requests into a two-entry queue while the back end is busy,
// and a finished result waits in an output register so the next request can start.
module rational_arithmetic_unit_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [rau_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // res_num [31:0], res_den [63:32]
    output logic [rau_pkg::OUT_DATA_W-1:0] m_tdata,
    // fault
    output logic                           m_tuser
);
    import rau_pkg::*;

    logic     push_valid;
    logic     push_ready;
    job_t     push_job;
    logic     pop;
    logic     pop_valid;
    job_t     pop_job;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // accept and classify
    rau_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // request queue
    rau_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    // execution
    rau_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // serial signed divider
    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

// ----- hdl/rau_checker.sv -----
module rau_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rau_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a fault only comes from a 0/0 fraction, returned as is
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("fault result with nonzero fraction");

    // stalled result keeps valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    // opcodes the block does not implement
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic [W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [W-1:0] MOST_POS = 32'h7fff_ffff;

    localparam int RANDOM_PER_PHASE = 388;
    localparam int DRAIN_CYCLES     = 1800;

    // one result of the block
    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic         fault;
    } fraction_t;

    // one row of the directed table
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [W-1:0]    a_num;
        logic [W-1:0]    a_den;
        logic [W-1:0]    b_num;
        logic [W-1:0]    b_den;
        logic            typed;
        logic [W-1:0]    e_num;
        logic [W-1:0]    e_den;
        logic            e_fault;
    } stim_row_t;

    localparam int N_DIRECTED = 25;

    // directed rows; expected values typed in only where they are obvious
    stim_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{OP_ADD,  1, 2, 1, 3, 1'b1, 5, 6, 1'b0},
        '{OP_SUB,  1, 2, 1, 3, 1'b1, 1, 6, 1'b0},
        '{OP_MUL,  2, 3, 5, 7, 1'b1, 10, 21, 1'b0},
        '{OP_DIV,  2, 3, 5, 7, 1'b1, 14, 15, 1'b0},
        '{OP_ADD,  0, 0, 0, 0, 1'b1, 0, 0, 1'b0},
        '{OP_ADD,  1, 0, 1, 0, 1'b1, 0, 0, 1'b0},
        '{OP_DIV,  3, 4, 0, 5, 1'b1, 15, 0, 1'b0},
        '{OP_SIMP, 0, 0, 9, 9, 1'b1, 0, 0, 1'b1},
        '{OP_SIMP, 6, 4, 0, 0, 1'b1, 3, 2, 1'b0},
        '{OP_SIMP, -6, 4, 0, 0, 1'b1, 3, -2, 1'b0},
        '{OP_SIMP, MOST_NEG, -1, 0, 0, 1'b1, MOST_NEG, 1, 1'b0},
        '{OP_SIMP, 0, 5, 0, 0, 1'b1, 0, 1, 1'b0},
        '{OP_SIMP, 7, 0, 0, 0, 1'b1, 1, 0, 1'b0},
        '{OP_SIMP, 0, -3, 0, 0, 1'b1, 0, 1, 1'b0},
        '{OP_SIMP, MOST_POS, MOST_POS, 0, 0, 1'b0, 0, 0, 1'b0},
        '{OP_SIMP, MOST_NEG, MOST_NEG, 0, 0, 1'b0, 0, 0, 1'b0},
        '{OP_SIMP, 1836311903, 1134903170, 0, 0, 1'b0, 0, 0, 1'b0},
        '{OP_SIMP, MOST_NEG, 2, 0, 0, 1'b0, 0, 0, 1'b0},
        '{OP_MUL,  MOST_POS, MOST_POS, MOST_POS, MOST_POS, 1'b0, 0, 0, 1'b0},
        '{OP_MUL,  MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 1'b0, 0, 0, 1'b0},
        '{OP_ADD,  -1, -1, -1, -1, 1'b0, 0, 0, 1'b0},
        '{OP_SUB,  MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, 1'b0, 0, 0, 1'b0},
        '{OP_DIV,  MOST_NEG, -1, -1, MOST_NEG, 1'b0, 0, 0, 1'b0},
        '{OP_RSVD5, 1, 2, 3, 4, 1'b1, 0, 0, 1'b0},
        '{OP_RSVD7, MOST_POS, MOST_NEG, -1, 1, 1'b1, 0, 0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // idle chances in percent, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    fraction_t pending_fractions [$];
    int        mismatches     = 0;
    int        results_seen   = 0;
    int        faults_seen    = 0;
    int        op_count [0:7] = '{default: 0};

    rational_arithmetic_unit_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // magnitude of a two's complement value, most negative stays as 2^31
    function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
        return x[W-1] ? -x : x;
    endfunction

    // truncating signed quotient, wraps for most negative by minus one
    function automatic logic [W-1:0] trunc_quot(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] q;
        q = magnitude(a) / magnitude(b);
        return (a[W-1] ^ b[W-1]) ? -q : q;
    endfunction

    // expected result of one request
    function automatic fraction_t rational_result(input logic [OP_W-1:0] op,
                                                  input logic [W-1:0] an, input logic [W-1:0] ad,
                                                  input logic [W-1:0] bn, input logic [W-1:0] bd);
        fraction_t    res;
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] r;
        res = '0;
        case (op)
            OP_ADD: begin
                res.num = an * bd + ad * bn;
                res.den = ad * bd;
            end
            OP_SUB: begin
                res.num = an * bd - ad * bn;
                res.den = ad * bd;
            end
            OP_MUL: begin
                res.num = an * bn;
                res.den = ad * bd;
            end
            OP_DIV: begin
                res.num = an * bd;
                res.den = ad * bn;
            end
            OP_SIMP: begin
                // euclid with remainder taking the sign of the dividend
                x = an;
                y = ad;
                while (y != 0) begin
                    r = magnitude(x) % magnitude(y);
                    if (x[W-1])
                        r = -r;
                    x = y;
                    y = r;
                end
                if (x == 0) begin
                    res.num   = an;
                    res.den   = ad;
                    res.fault = 1'b1;
                end else begin
                    res.num = trunc_quot(an, x);
                    res.den = trunc_quot(ad, x);
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // operand mix: full range, small values, extremes and powers of two
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6, 7:       v = $urandom_range(0, 200) - 100;
            8: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = '1;
                    3:       v = MOST_POS;
                    default: v = MOST_NEG;
                endcase
            end
            default: begin
                v = 32'd1 << $urandom_range(0, W - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // one request on the input stream, with an optional gap in front
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [W-1:0] an, input logic [W-1:0] ad,
                                input logic [W-1:0] bn, input logic [W-1:0] bd,
                                input logic typed, input fraction_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bd, bn, ad, an};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        op_count[op] = op_count[op] + 1;
        if (typed)
            pending_fractions.push_back(typed_res);
        else
            pending_fractions.push_back(rational_result(op, an, ad, bn, bd));
    endtask

    // result side: random back-pressure and comparison with the oldest expectation
    initial begin
        fraction_t exp_res;
        fraction_t got;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.num   = m_tdata[W-1:0];
                got.den   = m_tdata[2*W-1:W];
                got.fault = m_tuser;
                results_seen = results_seen + 1;
                if (got.fault)
                    faults_seen = faults_seen + 1;
                if (pending_fractions.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result num %h den %h fault %b",
                             $time, got.num, got.den, got.fault);
                end else begin
                    exp_res = pending_fractions.pop_front();
                    if (got.num !== exp_res.num) begin
                        mismatches = mismatches + 1;
                        $display("%0t: res_num expected %h actual %h",
                                 $time, exp_res.num, got.num);
                    end
                    if (got.den !== exp_res.den) begin
                        mismatches = mismatches + 1;
                        $display("%0t: res_den expected %h actual %h",
                                 $time, exp_res.den, got.den);
                    end
                    if (got.fault !== exp_res.fault) begin
                        mismatches = mismatches + 1;
                        $display("%0t: fault expected %b actual %b",
                                 $time, exp_res.fault, got.fault);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // reset, directed table, random phases, drain
    initial begin
        stim_row_t       row;
        fraction_t       typed_res;
        logic [OP_W-1:0] op;
        logic [W-1:0]    an;
        logic [W-1:0]    ad;
        logic [W-1:0]    bn;
        logic [W-1:0]    bd;
        logic [W-1:0]    k;
        int              sel;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ADD;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            typed_res = '{num: row.e_num, den: row.e_den, fault: row.e_fault};
            send_request(row.op, row.a_num, row.a_den, row.b_num, row.b_den,
                         row.typed, typed_res);
        end

        // random requests in four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 18)
                    op = OP_ADD;
                else if (sel < 36)
                    op = OP_SUB;
                else if (sel < 54)
                    op = OP_MUL;
                else if (sel < 72)
                    op = OP_DIV;
                else if (sel < 94)
                    op = OP_SIMP;
                else
                    op = OP_W'(OP_RSVD5 + $urandom_range(0, 2));
                an = random_operand();
                ad = random_operand();
                bn = random_operand();
                bd = random_operand();
                // simplify: mostly fractions with a common factor, a few 0/0
                if (op == OP_SIMP) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 3) begin
                        an = '0;
                        ad = '0;
                    end else if (sel < 55) begin
                        k  = $urandom_range(1, 1000);
                        an = k * $urandom_range(0, 100000);
                        ad = k * $urandom_range(1, 100000);
                        if ($urandom_range(0, 1))
                            an = -an;
                        if ($urandom_range(0, 1))
                            ad = -ad;
                    end
                end
                send_request(op, an, ad, bn, bd, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // let every result arrive, then watch for strays
        while (pending_fractions.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("requests: add %0d, sub %0d, mul %0d, div %0d, simplify %0d, unused ops %0d",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_SIMP], op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7]);
        $display("results checked %0d, zero-gcd faults %0d, four idling phases",
                 results_seen, faults_seen);
        if (mismatches == 0 && pending_fractions.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_fifo.sv
hdl/rau_div.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit_core.sv
hdl/rau_checker.sv
test/testbench.sv
